/* hdl/hml_pkg.sv */
// Shared types and constants for the HTML markup lexer state tracker.
package hml_pkg;

	typedef enum logic [3:0] {
		ST_NORMAL = 4'd0,
		ST_TAG0   = 4'd1,
		ST_TAG    = 4'd2,
		ST_EQL    = 4'd3,
		ST_QUOTE  = 4'd4,
		ST_DQUOTE = 4'd5,
		ST_VALUE  = 4'd6,
		ST_AMP    = 4'd7,
		ST_CMNT1  = 4'd8,
		ST_CMNT2  = 4'd9,
		ST_CMNT   = 4'd10,
		ST_NCMNT1 = 4'd11,
		ST_NCMNT2 = 4'd12,
		ST_NCMNT3 = 4'd13,
		ST_IRRTAG = 4'd14
	} lex_state_t;

	localparam logic [7:0] CH_LT     = 8'h3C; // '<'
	localparam logic [7:0] CH_AMP    = 8'h26; // '&'
	localparam logic [7:0] CH_BANG   = 8'h21; // '!'
	localparam logic [7:0] CH_GT     = 8'h3E; // '>'
	localparam logic [7:0] CH_EQ     = 8'h3D; // '='
	localparam logic [7:0] CH_DASH   = 8'h2D; // '-'
	localparam logic [7:0] CH_SEMI   = 8'h3B; // ';'
	localparam logic [7:0] CH_HASH   = 8'h23; // '#'
	localparam logic [7:0] CH_USCORE = 8'h5F; // '_'
	localparam logic [7:0] CH_UPPER_D = 8'h44; // 'D'
	localparam logic [7:0] CH_LOWER_D = 8'h64; // 'd'
	localparam logic [7:0] CH_SQUOTE = 8'h27; // '\''
	localparam logic [7:0] CH_DQUOTE = 8'h22; // '"'
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_letter_or_digit(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

/* hdl/hml_in_if.sv */
// Input byte channel: valid/ready handshake with one raw byte per item.
interface hml_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

/* hdl/hml_out_if.sv */
// Result channel: valid/ready handshake with text flag and new lexer state.
interface hml_out_if;
	logic       valid;
	logic       ready;
	logic       is_text;
	logic [3:0] new_state;

	modport source (output valid, output is_text, output new_state, input ready);
	modport sink   (input valid, input is_text, input new_state, output ready);
endinterface

/* hdl/hml_next.sv */
// Next-state and text-flag logic of the lexer for one byte.
module hml_next (
	input  hml_pkg::lex_state_t state,
	input  logic [7:0]          c,
	output hml_pkg::lex_state_t next,
	output logic                text
);

	logic in_normal;

	always_comb begin
		next = state;
		unique case (state)
			hml_pkg::ST_TAG0, hml_pkg::ST_TAG: begin
				if (state == hml_pkg::ST_TAG0 && c == hml_pkg::CH_BANG)
					next = hml_pkg::ST_CMNT1;
				else if (c == hml_pkg::CH_GT)
					next = hml_pkg::ST_NORMAL;
				else if (c == hml_pkg::CH_EQ)
					next = hml_pkg::ST_EQL;
				else
					next = hml_pkg::ST_TAG;
			end
			hml_pkg::ST_EQL: begin
				if (c == hml_pkg::CH_DQUOTE)
					next = hml_pkg::ST_DQUOTE;
				else if (c == hml_pkg::CH_SQUOTE)
					next = hml_pkg::ST_QUOTE;
				else if (hml_pkg::is_ws(c))
					next = hml_pkg::ST_EQL;
				else if (c == hml_pkg::CH_GT)
					next = hml_pkg::ST_NORMAL;
				else
					next = hml_pkg::ST_VALUE;
			end
			hml_pkg::ST_QUOTE: begin
				if (c == hml_pkg::CH_SQUOTE)
					next = hml_pkg::ST_TAG;
			end
			hml_pkg::ST_DQUOTE: begin
				if (c == hml_pkg::CH_DQUOTE)
					next = hml_pkg::ST_TAG;
			end
			hml_pkg::ST_VALUE: begin
				if (c == hml_pkg::CH_GT)
					next = hml_pkg::ST_NORMAL;
				else if (hml_pkg::is_ws(c))
					next = hml_pkg::ST_TAG;
			end
			hml_pkg::ST_AMP: begin
				// entity ends on ';' or on anything outside its character set
				if (c == hml_pkg::CH_SEMI || (c != hml_pkg::CH_HASH &&
					c != hml_pkg::CH_USCORE && !hml_pkg::is_letter_or_digit(c)))
					next = hml_pkg::ST_NORMAL;
			end
			hml_pkg::ST_CMNT1: begin
				if (c == hml_pkg::CH_DASH)
					next = hml_pkg::ST_CMNT2;
				else if (c == hml_pkg::CH_GT)
					next = hml_pkg::ST_NORMAL;
				else if (c == hml_pkg::CH_UPPER_D || c == hml_pkg::CH_LOWER_D)
					next = hml_pkg::ST_TAG; // doctype
				else
					next = hml_pkg::ST_IRRTAG;
			end
			hml_pkg::ST_CMNT2: begin
				if (c == hml_pkg::CH_DASH)
					next = hml_pkg::ST_CMNT;
				else if (c == hml_pkg::CH_GT)
					next = hml_pkg::ST_NORMAL;
				else
					next = hml_pkg::ST_IRRTAG;
			end
			hml_pkg::ST_CMNT: begin
				if (c == hml_pkg::CH_DASH)
					next = hml_pkg::ST_NCMNT1;
			end
			hml_pkg::ST_NCMNT1: begin
				if (c == hml_pkg::CH_DASH)
					next = hml_pkg::ST_NCMNT2;
				else
					next = hml_pkg::ST_CMNT;
			end
			hml_pkg::ST_NCMNT2, hml_pkg::ST_NCMNT3: begin
				if (c == hml_pkg::CH_GT)
					next = hml_pkg::ST_NORMAL;
				else if (c == hml_pkg::CH_DASH)
					next = (state == hml_pkg::ST_NCMNT2) ? hml_pkg::ST_NCMNT2
						: hml_pkg::ST_NCMNT1;
				else if (hml_pkg::is_ws(c))
					next = hml_pkg::ST_NCMNT3;
				else
					next = hml_pkg::ST_CMNT;
			end
			hml_pkg::ST_IRRTAG: begin
				if (c == hml_pkg::CH_GT)
					next = hml_pkg::ST_NORMAL;
			end
			default: begin
				// normal text, and the unused code fifteen
				if (c == hml_pkg::CH_LT)
					next = hml_pkg::ST_TAG0;
				else if (c == hml_pkg::CH_AMP)
					next = hml_pkg::ST_AMP;
				else
					next = hml_pkg::ST_NORMAL;
			end
		endcase
	end

	always_comb begin
		in_normal = (state == hml_pkg::ST_NORMAL) || (state == 4'hF);
		text      = in_normal && (c != hml_pkg::CH_LT);
	end

endmodule

/* hdl/html_markup_lexer_state.sv */
// Top level of the HTML markup lexer state tracker.
// One byte is taken per item and one result item comes out per byte, with the
// text flag and the lexer state after that byte. A byte is registered on
// entry, runs through the next-state logic against the current lexer state
// and lands in the result register; a new byte is taken every cycle while
// the result side keeps up. The lexer state is a single 4-bit register that
// advances when a byte moves into the result register; reset puts it in
// normal text.
module html_markup_lexer_state (
	input  logic          clk,
	input  logic          arst_n,
	hml_in_if.sink        stream,
	hml_out_if.source     result
);

	logic                v_s1;
	logic [7:0]          byte_s1;
	logic                v_s2;
	logic                text_s2;
	hml_pkg::lex_state_t state_q;
	hml_pkg::lex_state_t next;
	logic                text;
	logic                adv1;

	assign adv1         = v_s1 && (result.ready || !v_s2);
	assign stream.ready = !v_s1 || adv1;

	hml_next u_next (
		.state (state_q),
		.c     (byte_s1),
		.next  (next),
		.text  (text)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			state_q <= hml_pkg::ST_NORMAL;
		end else begin
			if (stream.ready)
				v_s1 <= stream.valid;
			if (adv1) begin
				v_s2    <= 1'b1;
				state_q <= next;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid)
			byte_s1 <= stream.in_byte;
	end

	always_ff @(posedge clk) begin
		if (adv1)
			text_s2 <= text;
	end

	assign result.valid     = v_s2;
	assign result.is_text   = text_s2;
	assign result.new_state = state_q;

`ifndef NO_ASSERTIONS
	// a text byte leaves the lexer in normal text or in an entity
	a_text_state: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.is_text) |->
		(state_q == hml_pkg::ST_NORMAL || state_q == hml_pkg::ST_AMP))
		else $error("text byte with markup state");

	// input stalls only when both stages are full and the result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> (v_s1 && v_s2 && !result.ready))
		else $error("input stalled with room in pipeline");

	// state register only moves when a new result is loaded
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv1) |-> $stable(state_q))
		else $error("lexer state changed without an item");

	// the unused state code never appears
	a_no_code15: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.new_state != 4'hF))
		else $error("unused lexer state code");
`endif

endmodule

/* tb/html_markup_lexer_state_tb.sv */
`timescale 1ns / 100ps
// Testbench for html_markup_lexer_state: markup byte streams, lexer state prediction, checks.
module html_markup_lexer_state_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 270;

	typedef struct packed {
		logic                is_text;
		hml_pkg::lex_state_t new_state;
	} lex_result_t;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic clk;
	logic arst_n;

	hml_in_if  in_ch ();
	hml_out_if out_ch ();

	html_markup_lexer_state dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (in_ch),
		.result (out_ch)
	);

	lex_result_t         pending_results[$];
	hml_pkg::lex_state_t lexer_now;
	int                  fails;
	int                  items_sent;
	int                  results_seen;
	int                  cycles;
	int                  burst_left;
	bit                  gaps_on;
	rx_mode_t            rx_mode;
	int                  hold_len;
	int                  hold_tag;
	int                  hold_seen;
	int                  hold_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic logic ws_byte(logic [7:0] c);
		return (c == hml_pkg::CH_SPACE) || (c >= hml_pkg::CH_TAB && c <= hml_pkg::CH_CR);
	endfunction

	function automatic hml_pkg::lex_state_t tag_next(logic [7:0] c);
		if (c == hml_pkg::CH_GT)
			return hml_pkg::ST_NORMAL;
		if (c == hml_pkg::CH_EQ)
			return hml_pkg::ST_EQL;
		return hml_pkg::ST_TAG;
	endfunction

	function automatic lex_result_t lex_next(hml_pkg::lex_state_t cur, logic [7:0] c);
		lex_result_t r;
		logic        word;
		r.is_text = 1'b0;
		r.new_state = cur;
		word = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		case (cur)
		hml_pkg::ST_TAG0:
			r.new_state = (c == hml_pkg::CH_BANG) ? hml_pkg::ST_CMNT1 : tag_next(c);
		hml_pkg::ST_TAG: r.new_state = tag_next(c);
		hml_pkg::ST_EQL: begin
			if (c == hml_pkg::CH_DQUOTE)
				r.new_state = hml_pkg::ST_DQUOTE;
			else if (c == hml_pkg::CH_SQUOTE)
				r.new_state = hml_pkg::ST_QUOTE;
			else if (ws_byte(c))
				r.new_state = hml_pkg::ST_EQL;
			else if (c == hml_pkg::CH_GT)
				r.new_state = hml_pkg::ST_NORMAL;
			else
				r.new_state = hml_pkg::ST_VALUE;
		end
		hml_pkg::ST_QUOTE: if (c == hml_pkg::CH_SQUOTE) r.new_state = hml_pkg::ST_TAG;
		hml_pkg::ST_DQUOTE: if (c == hml_pkg::CH_DQUOTE) r.new_state = hml_pkg::ST_TAG;
		hml_pkg::ST_VALUE: begin
			if (c == hml_pkg::CH_GT)
				r.new_state = hml_pkg::ST_NORMAL;
			else if (ws_byte(c))
				r.new_state = hml_pkg::ST_TAG;
		end
		hml_pkg::ST_AMP: begin
			// entity ends on ';' or on anything outside its character set
			if (c == hml_pkg::CH_SEMI ||
				!(c == hml_pkg::CH_HASH || c == hml_pkg::CH_USCORE || word))
				r.new_state = hml_pkg::ST_NORMAL;
		end
		hml_pkg::ST_CMNT1: begin
			if (c == hml_pkg::CH_DASH)
				r.new_state = hml_pkg::ST_CMNT2;
			else if (c == hml_pkg::CH_GT)
				r.new_state = hml_pkg::ST_NORMAL;
			else if (c == hml_pkg::CH_UPPER_D || c == hml_pkg::CH_LOWER_D)
				r.new_state = hml_pkg::ST_TAG;
			else
				r.new_state = hml_pkg::ST_IRRTAG;
		end
		hml_pkg::ST_CMNT2: begin
			if (c == hml_pkg::CH_DASH)
				r.new_state = hml_pkg::ST_CMNT;
			else if (c == hml_pkg::CH_GT)
				r.new_state = hml_pkg::ST_NORMAL;
			else
				r.new_state = hml_pkg::ST_IRRTAG;
		end
		hml_pkg::ST_CMNT: if (c == hml_pkg::CH_DASH) r.new_state = hml_pkg::ST_NCMNT1;
		hml_pkg::ST_NCMNT1:
			r.new_state = (c == hml_pkg::CH_DASH) ? hml_pkg::ST_NCMNT2 : hml_pkg::ST_CMNT;
		hml_pkg::ST_NCMNT2, hml_pkg::ST_NCMNT3: begin
			if (c == hml_pkg::CH_GT)
				r.new_state = hml_pkg::ST_NORMAL;
			else if (c == hml_pkg::CH_DASH)
				r.new_state = (cur == hml_pkg::ST_NCMNT2) ? hml_pkg::ST_NCMNT2
					: hml_pkg::ST_NCMNT1;
			else if (ws_byte(c))
				r.new_state = hml_pkg::ST_NCMNT3;
			else
				r.new_state = hml_pkg::ST_CMNT;
		end
		hml_pkg::ST_IRRTAG: if (c == hml_pkg::CH_GT) r.new_state = hml_pkg::ST_NORMAL;
		default: begin
			if (c == hml_pkg::CH_LT) begin
				r.new_state = hml_pkg::ST_TAG0;
			end else begin
				r.is_text = 1'b1;
				r.new_state = (c == hml_pkg::CH_AMP) ? hml_pkg::ST_AMP : hml_pkg::ST_NORMAL;
			end
		end
		endcase
		return r;
	endfunction

	// ---------------- sender ----------------

	task automatic send_byte(input logic [7:0] b);
		lex_result_t r;
		int          gap;
		if (burst_left <= 0) begin
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		r = lex_next(lexer_now, b);
		lexer_now = r.new_state;
		pending_results.push_back(r);
		items_sent++;
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// ---------------- receiver and checker ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_seen = 0;
			hold_cnt = 0;
		end else begin
			if (hold_tag != hold_seen) begin
				hold_seen = hold_tag;
				hold_cnt = hold_len;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
				RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: out_ch.ready <= ((cycles % 7) < 4);
				default: out_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
		fails++;
	endtask

	always @(posedge clk) begin : check_result
		lex_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, new_state", int'(out_ch.new_state), 0);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.is_text !== want.is_text)
					report_mismatch("is_text", int'(out_ch.is_text), int'(want.is_text));
				if (out_ch.new_state !== want.new_state)
					report_mismatch("new_state", int'(out_ch.new_state),
						int'(want.new_state));
			end
			results_seen++;
		end
	end

	// ---------------- markup generators ----------------

	function automatic logic [7:0] any_byte_but(input logic [7:0] x);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (b == x)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic logic [7:0] letter();
		return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] ws_char();
		return ($urandom_range(0, 5) == 5) ? hml_pkg::CH_SPACE
			: hml_pkg::CH_TAB + 8'($urandom_range(0, 4));
	endfunction

	task automatic send_text_run();
		logic [7:0] b;
		int         k;
		repeat ($urandom_range(1, 8)) begin
			k = $urandom_range(0, 9);
			if (k == 0) begin
				send_byte(hml_pkg::CH_AMP);
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 3))
					0: send_byte("0" + 8'($urandom_range(0, 9)));
					1: send_byte(hml_pkg::CH_HASH);
					2: send_byte(hml_pkg::CH_USCORE);
					default: send_byte(letter());
					endcase
				end
				send_byte($urandom_range(0, 2) ? hml_pkg::CH_SEMI
					: any_byte_but(hml_pkg::CH_LT));
			end else if (k == 1) begin
				send_byte(ws_char());
			end else if (k == 2) begin
				send_byte(8'($urandom_range(128, 255)));
			end else begin
				b = 8'($urandom_range(32, 126));
				while (b == hml_pkg::CH_LT)
					b = 8'($urandom_range(32, 126));
				send_byte(b);
			end
		end
	endtask

	task automatic send_tag();
		send_byte(hml_pkg::CH_LT);
		if ($urandom_range(0, 3) == 0)
			send_byte("/");
		repeat ($urandom_range(1, 4)) send_byte(letter());
		repeat ($urandom_range(0, 3)) begin
			send_byte(ws_char());
			repeat ($urandom_range(1, 3)) send_byte(letter());
			if ($urandom_range(0, 3) != 0) begin
				send_byte(hml_pkg::CH_EQ);
				if ($urandom_range(0, 3) == 0)
					send_byte(ws_char());
				case ($urandom_range(0, 4))
				0: begin
					send_byte(hml_pkg::CH_SQUOTE);
					repeat ($urandom_range(0, 5))
						send_byte(any_byte_but(hml_pkg::CH_SQUOTE));
					send_byte(hml_pkg::CH_SQUOTE);
				end
				1: begin
					send_byte(hml_pkg::CH_DQUOTE);
					repeat ($urandom_range(0, 5))
						send_byte(any_byte_but(hml_pkg::CH_DQUOTE));
					send_byte(hml_pkg::CH_DQUOTE);
				end
				2, 3: repeat ($urandom_range(1, 4)) send_byte(letter());
				default: begin
					// value cut short by the closing bracket
					send_byte(hml_pkg::CH_GT);
					return;
				end
				endcase
			end
		end
		if ($urandom_range(0, 2) == 0)
			send_byte(ws_char());
		send_byte(hml_pkg::CH_GT);
	endtask

	task automatic send_comment();
		send_str("<!--");
		repeat ($urandom_range(0, 10)) begin
			case ($urandom_range(0, 4))
			0: send_byte(hml_pkg::CH_DASH);
			1: send_byte(ws_char());
			default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end
		// every closing form below ends a comment from any comment state
		case ($urandom_range(0, 2))
		0: send_str("-->");
		1: send_str("-- >");
		default: send_str("--->");
		endcase
	endtask

	task automatic send_bang_other();
		logic [7:0] b;
		send_str("<!");
		case ($urandom_range(0, 4))
		0: begin
			send_byte($urandom_range(0, 1) ? hml_pkg::CH_UPPER_D : hml_pkg::CH_LOWER_D);
			send_str("OCTYPE html>");
		end
		1: send_byte(hml_pkg::CH_GT);
		2: send_str("->");
		default: begin
			if ($urandom_range(0, 1)) begin
				send_byte(hml_pkg::CH_DASH);
				send_byte(any_byte_but(hml_pkg::CH_DASH));
			end else begin
				b = 8'($urandom_range(0, 255));
				while (b == hml_pkg::CH_DASH || b == hml_pkg::CH_GT ||
					b == hml_pkg::CH_UPPER_D || b == hml_pkg::CH_LOWER_D)
					b = 8'($urandom_range(0, 255));
				send_byte(b);
			end
			repeat ($urandom_range(0, 5)) send_byte(any_byte_but(hml_pkg::CH_GT));
			send_byte(hml_pkg::CH_GT);
		end
		endcase
	endtask

	task automatic send_fragment();
		case ($urandom_range(0, 7))
		0, 1, 2: send_text_run();
		3, 4: send_tag();
		5: send_comment();
		6: send_bang_other();
		default: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	// ---------------- tests ----------------

	task automatic test_directed();
		gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		send_byte(8'h00);
		send_byte(8'hFF);
		// entity closed by a space, then a tag with whitespace after '='
		send_str("&#_9 <a=\t'x'>");
		send_str("<!d>");
		send_str("<!--x-- -->");
		wait_drained();
	endtask

	task automatic test_random_markup(input int count, input bit gaps, input rx_mode_t mode);
		int stop_at;
		gaps_on = gaps;
		rx_mode = mode;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			send_fragment();
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		hold_len = 80;
		hold_tag++;
		repeat (6) send_tag();
	endtask

	task automatic test_drain_pause();
		gaps_on = 1'b1;
		rx_mode = RX_RANDOM;
		send_comment();
		send_text_run();
		wait_drained();
		send_tag();
		send_text_run();
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.in_byte <= 8'h00;
		lexer_now = hml_pkg::ST_NORMAL;
		fails = 0;
		items_sent = 0;
		results_seen = 0;
		cycles = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		hold_len = 0;
		hold_tag = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_markup(RANDOM_ITEMS / 3, 1'b1, RX_RANDOM);
		test_backpressure();
		test_random_markup(RANDOM_ITEMS / 3, 1'b0, RX_ALWAYS);
		test_drain_pause();
		test_random_markup(RANDOM_ITEMS / 3, 1'b1, RX_PATTERN);

		wait_drained();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
